[rtl/core/bfa_pkg.sv]
package bfa_pkg;

  // Field widths fixed by the request and result formats
  localparam int FRAME_W = 12;
  localparam int CNT_W   = 13;

  // Largest frame number the frame field can carry, plus one
  localparam int FIELD_LIMIT = 4096;

  // Defaults for the top-level parameters
  localparam int MAX_FRAMES_DEF = 4096;
  localparam int WORD_BITS_DEF  = 32;

  // frame_count after reset
  localparam logic [CNT_W-1:0] FC_RESET = CNT_W'(4096);

  // Operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_MARK  = 2'd2;
  localparam logic [1:0] OP_TEST  = 2'd3;

  // Result status codes
  localparam logic [1:0] STS_DONE = 2'd0;
  localparam logic [1:0] STS_FULL = 2'd1;
  localparam logic [1:0] STS_SKIP = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [FRAME_W-1:0] frame;
    logic               kernel_only;
    logic               writable;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] result_frame;
    logic               present;
    logic               rw;
    logic               user;
    logic               used_bit;
    logic [1:0]         status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_CHECK,
    S_RD,
    S_UPD,
    S_SRCH,
    S_SET,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr;        // clearing pass: zero one word
    logic load;       // capture the request
    logic div;        // compute the word index of the frame
    logic rd;         // read the word holding the frame, capture bit offset
    logic upd;        // modify the word, capture test bit and result
    logic scan_init;  // start the free-frame search
    logic scan;       // one search step
    logic set;        // mark found frame used, build allocate result
    logic fin_skip;   // result: skipped
    logic fin_none;   // result: no free frame
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       clr_last;
    logic [1:0] op;
    logic       frame_zero;
    logic       found;
    logic       none;
  } sts_t;

endpackage

[rtl/core/bfa_ctrl.sv]
module bfa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  bfa_pkg::sts_t sts,
  output bfa_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done
);
  import bfa_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        case (sts.op)
          OP_ALLOC: begin
            if (!sts.frame_zero) begin
              cmd.fin_skip = 1'b1;
              state_next   = S_DONE;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = S_SRCH;
            end
          end
          OP_FREE: begin
            if (sts.frame_zero) begin
              cmd.fin_skip = 1'b1;
              state_next   = S_DONE;
            end else begin
              cmd.div    = 1'b1;
              state_next = S_RD;
            end
          end
          default: begin
            cmd.div    = 1'b1;
            state_next = S_RD;
          end
        endcase
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_DONE;
      end
      S_SRCH: begin
        cmd.scan = 1'b1;
        if (sts.found) begin
          state_next = S_SET;
        end else if (sts.none) begin
          cmd.fin_none = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_SET: begin
        cmd.set    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // An accepted request never answers in the next cycle and keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("request accepted without going busy");

endmodule

[rtl/core/bfa_dp.sv]
module bfa_dp #(
  parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF,
  parameter int WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bfa_pkg::req_t             req,
  input  logic                      frame_count_we,
  input  logic [bfa_pkg::CNT_W-1:0] frame_count,
  input  bfa_pkg::cmd_t             cmd,
  output bfa_pkg::sts_t             sts,
  output bfa_pkg::rsp_t             res
);
  import bfa_pkg::*;

  localparam int NWORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BW     = $clog2(WORD_BITS);
  localparam int QW     = (AW > FRAME_W) ? AW : FRAME_W;
  // Search limit: never above the map or the frame field
  localparam int MAXC   = (MAX_FRAMES < FIELD_LIMIT) ? MAX_FRAMES : FIELD_LIMIT;
  localparam int BASE_W = CNT_W + 1;
  // Word index by reciprocal multiply, exact for every 12-bit frame
  localparam int KSH    = FRAME_W + BW + 1;
  localparam int RECIP  = ((2 ** KSH) + WORD_BITS - 1) / WORD_BITS;
  localparam int RW     = KSH + 1;
  localparam int PW     = FRAME_W + RW;
  localparam int MW     = $clog2(MAX_FRAMES + 1);
  localparam int CW     = (MW > FRAME_W) ? MW : FRAME_W + 1;

  // Captured request and configuration
  req_t               req_q;
  logic [CNT_W-1:0]   fc;
  logic [CNT_W-1:0]   lim;
  logic               in_map;

  // Address split
  logic [PW-1:0]      prod;
  logic [QW-1:0]      q_reg;
  logic [FRAME_W-1:0] ofs_full;
  logic [BW-1:0]      bofs;

  // Bitmap memory
  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] bmask;
  logic                 upd_wr;

  // Clearing pass
  logic [AW-1:0]      clr_idx;

  // Search pipeline
  logic [AW-1:0]      scan_idx;
  logic [BASE_W-1:0]  scan_base;
  logic [BASE_W-1:0]  scan_end;
  logic               issue_ok;
  logic               chk_vld;
  logic [AW-1:0]      chk_idx;
  logic [BASE_W-1:0]  chk_base;
  logic [BW-1:0]      zpos;
  logic               word_free;

  // Found frame
  logic [AW-1:0]        fnd_idx;
  logic [WORD_BITS-1:0] fnd_word;
  logic [BW-1:0]        fnd_pos;
  logic [FRAME_W-1:0]   fnd_frame;

  rsp_t res_q;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      fc <= FC_RESET;
    end else if (frame_count_we) begin
      fc <= frame_count;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) req_q <= req;
  end

  assign lim    = (fc > CNT_W'(MAXC)) ? CNT_W'(MAXC) : fc;
  assign in_map = CW'(req_q.frame) < CW'(MAX_FRAMES);

  // Word index and bit offset of the request frame
  assign prod     = PW'(req_q.frame) * PW'(RECIP);
  assign ofs_full = req_q.frame - FRAME_W'(q_reg * WORD_BITS);

  always_ff @(posedge clk) begin
    if (cmd.div) q_reg <= QW'(prod >> KSH);
    if (cmd.rd) bofs <= ofs_full[BW-1:0];
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr) begin
      clr_idx <= clr_idx + AW'(1);
    end
  end

  // Search: issue one word read a cycle, check the word read the cycle before
  assign scan_end = scan_base + BASE_W'(WORD_BITS);
  assign issue_ok = scan_end <= {1'b0, lim};
  assign word_free = chk_vld && (rd_data != {WORD_BITS{1'b1}});

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld <= 1'b0;
    end else if (cmd.scan_init) begin
      chk_vld <= 1'b0;
    end else if (cmd.scan) begin
      chk_vld <= issue_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_idx  <= '0;
      scan_base <= '0;
    end else if (cmd.scan && issue_ok) begin
      scan_idx  <= scan_idx + AW'(1);
      scan_base <= scan_end;
    end
    if (cmd.scan) begin
      chk_idx  <= scan_idx;
      chk_base <= scan_base;
    end
  end

  // Lowest clear bit of the checked word
  always_comb begin
    zpos = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!rd_data[j]) zpos = BW'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && word_free) begin
      fnd_idx   <= chk_idx;
      fnd_word  <= rd_data;
      fnd_pos   <= zpos;
      fnd_frame <= chk_base[FRAME_W-1:0] + FRAME_W'(zpos);
    end
  end

  // Memory port selection
  assign bmask  = WORD_BITS'(1) << bofs;
  assign upd_wr = cmd.upd && in_map && ((req_q.op == OP_FREE) || (req_q.op == OP_MARK));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = q_reg[AW-1:0];
    if (cmd.rd) begin
      rd_en = 1'b1;
    end else if (cmd.scan && issue_ok) begin
      rd_en   = 1'b1;
      rd_addr = scan_idx;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_idx;
    wr_data = '0;
    if (cmd.clr) begin
      wr_en = 1'b1;
    end else if (upd_wr) begin
      wr_en   = 1'b1;
      wr_addr = q_reg[AW-1:0];
      wr_data = (req_q.op == OP_MARK) ? (rd_data | bmask) : (rd_data & ~bmask);
    end else if (cmd.set) begin
      wr_en   = 1'b1;
      wr_addr = fnd_idx;
      wr_data = fnd_word | (WORD_BITS'(1) << fnd_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.fin_skip || cmd.fin_none || cmd.upd || cmd.set) begin
      res_q.result_frame <= req_q.frame;
      res_q.present      <= 1'b0;
      res_q.rw           <= 1'b0;
      res_q.user         <= 1'b0;
      res_q.used_bit     <= 1'b0;
      res_q.status       <= STS_DONE;
      if (cmd.fin_skip) res_q.status <= STS_SKIP;
      if (cmd.fin_none) res_q.status <= STS_FULL;
      if (cmd.upd) res_q.used_bit <= (req_q.op == OP_TEST) && in_map && rd_data[bofs];
      if (cmd.set) begin
        res_q.result_frame <= fnd_frame;
        res_q.present      <= 1'b1;
        res_q.rw           <= req_q.writable;
        res_q.user         <= !req_q.kernel_only;
      end
    end
  end

  assign res = res_q;

  assign sts.clr_last   = clr_idx == AW'(NWORDS - 1);
  assign sts.op         = req_q.op;
  assign sts.frame_zero = req_q.frame == '0;
  assign sts.found      = word_free;
  assign sts.none       = !issue_ok && !chk_vld;

  // Only one source writes the bitmap in a cycle
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr, cmd.upd, cmd.set}))
    else $error("two bitmap writers in one cycle");

  // A committed allocation reports a present page with done status
  a_alloc_result: assert property (@(posedge clk) disable iff (rst)
    cmd.set |=> (res_q.present && (res_q.status == STS_DONE)))
    else $error("allocation result not present");

endmodule

[rtl/core/bitmap_frame_allocator.sv]
// Bitmap physical frame allocator. A request is taken when start is high and
// busy is low; its single result appears on res for exactly one cycle with
// done high, and must be captured then, since the block cannot be held off.
// Free, mark and test go from accept through check, word read and update to
// the result; an allocate of a nonzero frame or a free of frame 0 is skipped
// from check to the result. An allocate runs a first-free search that reads
// one bitmap word per cycle from the single-port-read bitmap memory, over the
// whole words inside frame_count. After reset the bitmap is cleared one word
// per cycle with busy high; frame_count may be written at any idle time.
module bitmap_frame_allocator #(
  parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF,
  parameter int WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  bfa_pkg::req_t             req,
  output logic                      done,
  output bfa_pkg::rsp_t             res,
  input  logic                      frame_count_we,
  input  logic [bfa_pkg::CNT_W-1:0] frame_count
);
  import bfa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  bfa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Bitmap, search and result datapath
  bfa_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .frame_count_we (frame_count_we),
    .frame_count    (frame_count),
    .cmd            (cmd),
    .sts            (sts),
    .res            (res)
  );

endmodule
